### sv/stt_pkg.sv
// Shared types and constants for the session timeout table.
// Used by stt_hash, stt_heap and session_timeout_table; depends on nothing.
package stt_pkg;

    localparam int KEY_W     = 60;
    localparam int CHAR_W    = 6;
    localparam int LIMIT_W   = 15;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 13;
    localparam int USER_W    = 2;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [TIME_W-1:0]  HASH_SEED  = 32'd5381;
    localparam logic [CHAR_W-1:0]  DIGIT_LAST = 6'd10;
    // code c maps to '0'+c-1 for digits and 'a'+c-11 for letters
    localparam logic [TIME_W-1:0]  DIGIT_OFS  = 32'd47;
    localparam logic [TIME_W-1:0]  ALPHA_OFS  = 32'd86;

    typedef enum logic [1:0] {
        OP_NEW     = 2'd0,
        OP_LOGOUT  = 2'd1,
        OP_CONNECT = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_HEAP_FULL  = 2'd2,
        ST_NO_MATCH   = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   secret;
        logic [TIME_W-1:0]  expiry;
        logic [LIMIT_W-1:0] limit;
        logic               logged_in;
        logic               used;
    } slot_rec_t;

    typedef enum logic [1:0] {
        HOP_PEEK = 2'd0,
        HOP_PUSH = 2'd1,
        HOP_POP  = 2'd2
    } heap_op_t;

    typedef struct packed {
        logic     start;
        heap_op_t op;
    } heap_cmd_t;

    typedef struct packed {
        logic              done;
        logic              empty;
        logic              full;
        logic [TIME_W-1:0] top_due;
    } heap_stat_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_CHAR,
        HS_MOD
    } hash_state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_PEEK,
        H_UP,
        H_UP_EV,
        H_DN_LAST,
        H_DN,
        H_DN_EV
    } heap_state_t;

    typedef enum logic [3:0] {
        C_CLEAR,
        C_IDLE,
        C_HASH,
        C_PRB_RD,
        C_PRB_EV,
        C_PUSH_WAIT,
        C_TK_PEEK,
        C_TK_TOP,
        C_TK_SLOT,
        C_TK_POP,
        C_DONE
    } ctl_state_t;

endpackage

### sv/stt_hash.sv
// Iterative djb2 hash of a packed key, one character per cycle, then
// reduction to a table index. Depends on stt_pkg.
module stt_hash #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int KEY_CHARS     = 10,
    parameter int IDX_W         = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [stt_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [IDX_W-1:0]          idx
);
    import stt_pkg::*;

    localparam int CH_W = $clog2(KEY_CHARS + 1);
    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);

    hash_state_t         state_reg, state_next;
    logic [TIME_W-1:0]   h_reg, h_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [4:0]          bit_reg, bit_next;
    logic [IDX_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                done_reg, done_next;

    logic [CHAR_W-1:0]   code;
    logic [TIME_W-1:0]   code_ascii;
    logic [TIME_W-1:0]   h_step;
    logic [IDX_W:0]      trial;
    logic [IDX_W:0]      trial_red;
    logic                char_end;

    assign code       = key_reg[CHAR_W-1:0];
    assign code_ascii = (code <= DIGIT_LAST) ? TIME_W'(code) + DIGIT_OFS
                                             : TIME_W'(code) + ALPHA_OFS;
    assign h_step     = (h_reg << 5) + h_reg + code_ascii;
    assign char_end   = (ch_reg == CH_W'(KEY_CHARS)) || (code == '0);
    // restoring remainder, one bit of the hash per cycle
    assign trial      = {rem_reg, h_reg[TIME_W-1]};
    assign trial_red  = (trial >= MODULUS) ? trial - MODULUS : trial;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (start)
                    state_next = HS_CHAR;
            end
            HS_CHAR:
            begin
                if (char_end)
                    state_next = IS_POW2 ? HS_IDLE : HS_MOD;
            end
            HS_MOD:
            begin
                if (bit_reg == 5'd31)
                    state_next = HS_IDLE;
            end
            default: state_next = HS_IDLE;
        endcase
    end

    always_comb
    begin
        h_next    = h_reg;
        key_next  = key_reg;
        ch_next   = ch_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        idx_next  = idx_reg;
        done_next = 1'b0;
        unique case (state_reg)
            HS_IDLE:
            begin
                h_next   = HASH_SEED;
                key_next = key;
                ch_next  = '0;
            end
            HS_CHAR:
            begin
                if (char_end)
                begin
                    rem_next = '0;
                    bit_next = '0;
                    if (IS_POW2)
                    begin
                        idx_next  = h_reg[IDX_W-1:0];
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    h_next   = h_step;
                    key_next = key_reg >> CHAR_W;
                    ch_next  = ch_reg + 1'b1;
                end
            end
            HS_MOD:
            begin
                rem_next = trial_red[IDX_W-1:0];
                h_next   = h_reg << 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 5'd31)
                begin
                    idx_next  = trial_red[IDX_W-1:0];
                    done_next = 1'b1;
                end
            end
            default: done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        key_reg <= key_next;
        ch_reg  <= ch_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        idx_reg <= idx_next;
    end

    assign done = done_reg;
    assign idx  = idx_reg;

endmodule

### sv/stt_heap.sv
// Min-heap of (due, slot) pairs in a one-write, two-read memory with
// registered reads; peek, push with sift-up, pop with sift-down. Depends on stt_pkg.
module stt_heap #(
    parameter int HEAP_ENTRIES = 8192,
    parameter int SLOT_W       = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stt_pkg::heap_cmd_t         cmd,
    input  logic [stt_pkg::TIME_W-1:0] push_due,
    input  logic [SLOT_W-1:0]          push_slot,
    output stt_pkg::heap_stat_t        stat,
    output logic [SLOT_W-1:0]          top_slot
);
    import stt_pkg::*;

    localparam int POS_W = $clog2(HEAP_ENTRIES);
    localparam int CNT_W = $clog2(HEAP_ENTRIES + 1);
    localparam int CMP_W = POS_W + 2;
    localparam int REC_W = TIME_W + SLOT_W;

    logic [REC_W-1:0] heap_mem [HEAP_ENTRIES];

    heap_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [REC_W-1:0] item_reg, item_next;
    logic [REC_W-1:0] top_reg, top_next;
    logic             done_reg, done_next;
    logic [REC_W-1:0] rd_a_reg, rd_b_reg;

    logic [POS_W-1:0] raddr_a, raddr_b, waddr;
    logic [REC_W-1:0] wdata;
    logic             we;

    logic [POS_W-1:0] parent;
    logic [CMP_W-1:0] left, right;
    logic             left_ok, right_ok;
    logic [TIME_W-1:0] due_item, due_a, due_b;
    logic             pick_l, pick_r;
    logic [CNT_W-1:0] cnt_dec;

    assign parent   = (pos_reg - 1'b1) >> 1;
    assign left     = {1'b0, pos_reg, 1'b1};
    assign right    = left + 1'b1;
    assign left_ok  = left < CMP_W'(cnt_reg);
    assign right_ok = right < CMP_W'(cnt_reg);
    assign due_item = item_reg[REC_W-1:SLOT_W];
    assign due_a    = rd_a_reg[REC_W-1:SLOT_W];
    assign due_b    = rd_b_reg[REC_W-1:SLOT_W];
    assign cnt_dec  = cnt_reg - 1'b1;
    // strict compare keeps the parent on ties, the left child before the right
    assign pick_l   = left_ok && (due_a < due_item);
    assign pick_r   = right_ok && (due_b < (pick_l ? due_a : due_item));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    priority case (cmd.op)
                        HOP_PEEK: state_next = H_PEEK;
                        HOP_PUSH: state_next = H_UP;
                        HOP_POP:  state_next = (cnt_reg > CNT_W'(1)) ? H_DN_LAST : H_IDLE;
                        default:  state_next = H_IDLE;
                    endcase
                end
            end
            H_PEEK:    state_next = H_IDLE;
            H_UP:      state_next = (pos_reg == '0) ? H_IDLE : H_UP_EV;
            H_UP_EV:   state_next = (due_a <= due_item) ? H_IDLE : H_UP;
            H_DN_LAST: state_next = H_DN;
            H_DN:      state_next = left_ok ? H_DN_EV : H_IDLE;
            H_DN_EV:   state_next = (pick_l || pick_r) ? H_DN : H_IDLE;
            default:   state_next = H_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        item_next = item_reg;
        top_next  = top_reg;
        done_next = 1'b0;
        raddr_a   = '0;
        raddr_b   = '0;
        we        = 1'b0;
        waddr     = pos_reg;
        wdata     = item_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    priority case (cmd.op)
                        HOP_PUSH:
                        begin
                            item_next = {push_due, push_slot};
                            pos_next  = cnt_reg[POS_W-1:0];
                            cnt_next  = cnt_reg + 1'b1;
                        end
                        HOP_POP:
                        begin
                            pos_next = '0;
                            if (cnt_reg > CNT_W'(1))
                            begin
                                cnt_next = cnt_dec;
                                raddr_a  = cnt_dec[POS_W-1:0];
                            end
                            else
                            begin
                                cnt_next  = '0;
                                done_next = 1'b1;
                            end
                        end
                        default: raddr_a = '0;
                    endcase
                end
            end
            H_PEEK:
            begin
                top_next  = rd_a_reg;
                done_next = 1'b1;
            end
            H_UP:
            begin
                if (pos_reg == '0)
                begin
                    we        = 1'b1;
                    done_next = 1'b1;
                end
                else
                    raddr_a = parent;
            end
            H_UP_EV:
            begin
                we = 1'b1;
                if (due_a <= due_item)
                    done_next = 1'b1;
                else
                begin
                    wdata    = rd_a_reg;
                    pos_next = parent;
                end
            end
            H_DN_LAST: item_next = rd_a_reg;
            H_DN:
            begin
                if (left_ok)
                begin
                    raddr_a = left[POS_W-1:0];
                    raddr_b = right[POS_W-1:0];
                end
                else
                begin
                    we        = 1'b1;
                    done_next = 1'b1;
                end
            end
            H_DN_EV:
            begin
                we = 1'b1;
                if (pick_r)
                begin
                    wdata    = rd_b_reg;
                    pos_next = right[POS_W-1:0];
                end
                else if (pick_l)
                begin
                    wdata    = rd_a_reg;
                    pos_next = left[POS_W-1:0];
                end
                else
                    done_next = 1'b1;
            end
            default: done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            heap_mem[waddr] <= wdata;
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        item_reg <= item_next;
        top_reg  <= top_next;
    end

    assign stat.done    = done_reg;
    assign stat.empty   = cnt_reg == '0;
    assign stat.full    = cnt_reg == CNT_W'(HEAP_ENTRIES);
    assign stat.top_due = top_reg[REC_W-1:SLOT_W];
    assign top_slot     = top_reg[SLOT_W-1:0];

endmodule

### sv/session_timeout_table.sv
// Session table with idle timeouts. One item is worked on at a time and each
// gives one result. New account, logout and connect hash the key (with a
// remainder step when TABLE_ENTRIES is not a power of two), then probe the
// slot memory; a new account or a renewal is pushed onto the heap with sift-up,
// and a tick pops each due pair from the heap with sift-down. After reset the
// slot memory is swept clear, one slot a cycle, before the first item is taken.
module session_timeout_table #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HEAP_ENTRIES  = 8192,
    parameter int KEY_CHARS     = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // user_key[59:0], secret[119:60], idle_limit[134:120], pad[135]
    input  logic [stt_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [stt_pkg::USER_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // expired_count[12:0], pad[15:13]
    output logic [stt_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [stt_pkg::USER_W-1:0]    m_tuser
);
    import stt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int PRB_W = $clog2(TABLE_ENTRIES + 1);

    slot_rec_t slot_mem [TABLE_ENTRIES];
    slot_rec_t slot_rd_reg;
    slot_rec_t slot_wdata;
    logic [IDX_W-1:0] slot_raddr, slot_waddr;
    logic             slot_we;

    ctl_state_t         state_reg, state_next;
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [KEY_W-1:0]   sec_reg, sec_next;
    logic [LIMIT_W-1:0] lim_reg, lim_next;
    logic [TIME_W-1:0]  tick_reg, tick_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PRB_W-1:0]   probe_reg, probe_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    status_t            status_reg, status_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;
    status_t            out_status_reg, out_status_next;

    logic [KEY_W-1:0]   key_norm, sec_norm;
    logic               accept;
    logic               hash_start, hash_done;
    logic [IDX_W-1:0]   hash_idx;
    heap_cmd_t          heap_cmd;
    heap_stat_t         heap_stat;
    logic [TIME_W-1:0]  push_due;
    logic [IDX_W-1:0]   push_slot;
    logic [IDX_W-1:0]   top_slot;

    logic               key_hit, last_probe, conn_ok, tick_hit, out_free;
    logic [IDX_W-1:0]   idx_wrap;
    logic [TIME_W-1:0]  new_expiry, renew_expiry;

    // cut keys at the first zero code and at KEY_CHARS codes
    always_comb
    begin
        logic alive_k, alive_s;
        alive_k  = 1'b1;
        alive_s  = 1'b1;
        key_norm = '0;
        sec_norm = '0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            alive_k = alive_k && (s_tdata[CHAR_W*i +: CHAR_W] != '0);
            alive_s = alive_s && (s_tdata[KEY_W + CHAR_W*i +: CHAR_W] != '0);
            if (alive_k)
                key_norm[CHAR_W*i +: CHAR_W] = s_tdata[CHAR_W*i +: CHAR_W];
            if (alive_s)
                sec_norm[CHAR_W*i +: CHAR_W] = s_tdata[KEY_W + CHAR_W*i +: CHAR_W];
        end
    end

    assign s_tready   = state_reg == C_IDLE;
    assign accept     = s_tvalid && s_tready;
    assign hash_start = accept && (op_t'(s_tuser) != OP_TICK);
    assign out_free   = !out_valid_reg || m_tready;

    assign key_hit      = slot_rd_reg.key == key_reg;
    assign last_probe   = probe_reg == PRB_W'(TABLE_ENTRIES - 1);
    assign idx_wrap     = (idx_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_reg + 1'b1;
    assign new_expiry   = tick_reg + TIME_W'(lim_reg);
    assign renew_expiry = tick_reg + TIME_W'(slot_rd_reg.limit);
    assign conn_ok      = slot_rd_reg.logged_in && (slot_rd_reg.expiry > tick_reg)
                          && (slot_rd_reg.secret == sec_reg);
    assign tick_hit     = (heap_stat.top_due == tick_reg) && slot_rd_reg.logged_in
                          && (slot_rd_reg.expiry == tick_reg) && (cnt_reg != COUNT_MAX);

    stt_hash #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_CHARS    (KEY_CHARS),
        .IDX_W        (IDX_W)
    ) u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .start(hash_start),
        .key  (key_norm),
        .done (hash_done),
        .idx  (hash_idx)
    );

    stt_heap #(
        .HEAP_ENTRIES(HEAP_ENTRIES),
        .SLOT_W      (IDX_W)
    ) u_heap (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (heap_cmd),
        .push_due (push_due),
        .push_slot(push_slot),
        .stat     (heap_stat),
        .top_slot (top_slot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_CLEAR:
            begin
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1))
                    state_next = C_IDLE;
            end
            C_IDLE:
            begin
                if (accept)
                    state_next = (op_t'(s_tuser) == OP_TICK) ? C_TK_PEEK : C_HASH;
            end
            C_HASH:
            begin
                if (hash_done)
                    state_next = C_PRB_RD;
            end
            C_PRB_RD: state_next = C_PRB_EV;
            C_PRB_EV:
            begin
                if (op_reg == OP_NEW)
                begin
                    if (slot_rd_reg.used)
                        state_next = last_probe ? C_DONE : C_PRB_RD;
                    else
                        state_next = heap_stat.full ? C_DONE : C_PUSH_WAIT;
                end
                else if (!slot_rd_reg.used)
                    state_next = C_DONE;
                else if (!key_hit)
                    state_next = last_probe ? C_DONE : C_PRB_RD;
                else if (op_reg == OP_CONNECT && conn_ok
                         && slot_rd_reg.expiry != renew_expiry && !heap_stat.full)
                    state_next = C_PUSH_WAIT;
                else
                    state_next = C_DONE;
            end
            C_PUSH_WAIT:
            begin
                if (heap_stat.done)
                    state_next = C_DONE;
            end
            C_TK_PEEK: state_next = heap_stat.empty ? C_DONE : C_TK_TOP;
            C_TK_TOP:
            begin
                if (heap_stat.done)
                    state_next = (heap_stat.top_due > tick_reg) ? C_DONE : C_TK_SLOT;
            end
            C_TK_SLOT: state_next = C_TK_POP;
            C_TK_POP:
            begin
                if (heap_stat.done)
                    state_next = C_TK_PEEK;
            end
            C_DONE:
            begin
                if (out_free)
                    state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        sec_next        = sec_reg;
        lim_next        = lim_reg;
        tick_next       = tick_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cnt_next    = out_cnt_reg;
        out_status_next = out_status_reg;
        slot_raddr      = idx_reg;
        slot_we         = 1'b0;
        slot_waddr      = idx_reg;
        slot_wdata      = slot_rd_reg;
        heap_cmd.start  = 1'b0;
        heap_cmd.op     = HOP_PEEK;
        push_due        = new_expiry;
        push_slot       = idx_reg;
        unique case (state_reg)
            C_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
            end
            C_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(s_tuser);
                    key_next    = key_norm;
                    sec_next    = sec_norm;
                    lim_next    = s_tdata[2*KEY_W +: LIMIT_W];
                    cnt_next    = '0;
                    status_next = ST_OK;
                    probe_next  = '0;
                    if (op_t'(s_tuser) == OP_TICK)
                        tick_next = tick_reg + 1'b1;
                end
            end
            C_HASH:
            begin
                if (hash_done)
                    idx_next = hash_idx;
            end
            C_PRB_EV:
            begin
                if (op_reg == OP_NEW)
                begin
                    if (slot_rd_reg.used)
                    begin
                        if (last_probe)
                            status_next = ST_TABLE_FULL;
                        else
                        begin
                            idx_next   = idx_wrap;
                            probe_next = probe_reg + 1'b1;
                        end
                    end
                    else if (heap_stat.full)
                        status_next = ST_HEAP_FULL;
                    else
                    begin
                        slot_we              = 1'b1;
                        slot_wdata.key       = key_reg;
                        slot_wdata.secret    = sec_reg;
                        slot_wdata.limit     = lim_reg;
                        slot_wdata.expiry    = new_expiry;
                        slot_wdata.used      = 1'b1;
                        slot_wdata.logged_in = 1'b1;
                        heap_cmd.start       = 1'b1;
                        heap_cmd.op          = HOP_PUSH;
                    end
                end
                else if (!slot_rd_reg.used)
                    status_next = ST_NO_MATCH;
                else if (!key_hit)
                begin
                    if (last_probe)
                        status_next = ST_NO_MATCH;
                    else
                    begin
                        idx_next   = idx_wrap;
                        probe_next = probe_reg + 1'b1;
                    end
                end
                else if (op_reg == OP_LOGOUT)
                begin
                    slot_we              = 1'b1;
                    slot_wdata.logged_in = 1'b0;
                end
                else if (!conn_ok)
                    status_next = ST_NO_MATCH;
                else if (slot_rd_reg.expiry != renew_expiry)
                begin
                    if (heap_stat.full)
                        status_next = ST_HEAP_FULL;
                    else
                    begin
                        slot_we           = 1'b1;
                        slot_wdata.expiry = renew_expiry;
                        push_due          = renew_expiry;
                        heap_cmd.start    = 1'b1;
                        heap_cmd.op       = HOP_PUSH;
                    end
                end
            end
            C_TK_PEEK:
            begin
                if (!heap_stat.empty)
                    heap_cmd.start = 1'b1;
            end
            C_TK_TOP: slot_raddr = top_slot;
            C_TK_SLOT:
            begin
                if (tick_hit)
                    cnt_next = cnt_reg + 1'b1;
                heap_cmd.start = 1'b1;
                heap_cmd.op    = HOP_POP;
            end
            C_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_cnt_next    = cnt_reg;
                    out_status_next = status_reg;
                end
            end
            default: slot_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_CLEAR;
            tick_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        sec_reg        <= sec_next;
        lim_reg        <= lim_next;
        idx_reg        <= idx_next;
        probe_reg      <= probe_next;
        cnt_reg        <= cnt_next;
        status_reg     <= status_next;
        out_cnt_reg    <= out_cnt_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W){1'b0}}, out_cnt_reg};
    assign m_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (heap_cmd.start && heap_cmd.op == HOP_PUSH) |-> !heap_stat.full)
        else $error("push issued into a full heap");

    a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cnt_reg != '0) |-> out_status_reg == ST_OK)
        else $error("expired count with error status");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_PRB_EV) |-> probe_reg < PRB_W'(TABLE_ENTRIES))
        else $error("probe ran past table size");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DONE && !out_free) |=> state_reg == C_DONE)
        else $error("result dropped while output stalled");
`endif

endmodule

### tb/sv/session_timeout_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for session_timeout_table: directed and random
// account, logout, connect and tick items, checked against an in-bench model.
// Depends on stt_pkg and the session_timeout_table RTL.
module testbench;
    import stt_pkg::*;

    localparam int TABLE_SLOTS = 4096;
    localparam int HEAP_SLOTS  = 8192;
    localparam int MAX_CHARS   = 10;
    localparam int RAND_ITEMS  = 1670;
    localparam int CYCLE_LIMIT = 40000000;

    typedef struct {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   secret;
        logic [LIMIT_W-1:0] idle_limit;
    } session_req_t;

    typedef struct {
        logic [COUNT_W-1:0] expired;
        status_t            status;
    } session_rsp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [USER_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [USER_W-1:0]    m_tuser;

    session_timeout_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // session model state
    logic [KEY_W-1:0]   tbl_key    [TABLE_SLOTS];
    logic [KEY_W-1:0]   tbl_secret [TABLE_SLOTS];
    bit   [TIME_W-1:0]  tbl_expiry [TABLE_SLOTS];
    bit   [LIMIT_W-1:0] tbl_limit  [TABLE_SLOTS];
    bit                 tbl_used   [TABLE_SLOTS];
    bit                 tbl_in     [TABLE_SLOTS];
    bit   [TIME_W-1:0]  due_time   [HEAP_SLOTS];
    bit   [11:0]        due_slot   [HEAP_SLOTS];
    int                 due_count;
    bit   [TIME_W-1:0]  now_tick;

    session_req_t       req_q[$];
    session_rsp_t       rsp_q[$];
    logic [KEY_W-1:0]   acct_key[$];
    logic [KEY_W-1:0]   acct_secret[$];

    int  errors;
    int  taken;
    int  returned;
    int  status_seen[4];
    int  max_expired;
    int  cycles;
    bit  s_took;

    // cut a packed string at its first zero code
    function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] out;
        logic [CHAR_W-1:0] c;
        out = '0;
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            c = k[CHAR_W*i +: CHAR_W];
            if (c == 0)
                break;
            out[CHAR_W*i +: CHAR_W] = c;
        end
        return out;
    endfunction

    function automatic int home_slot(logic [KEY_W-1:0] k);
        bit [31:0] h;
        bit [31:0] c;
        h = 32'd5381;
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            c = 32'(k[CHAR_W*i +: CHAR_W]);
            if (c == 0)
                break;
            h = h * 33 + (c <= 10 ? c + 47 : c + 86);
        end
        return int'(h % TABLE_SLOTS);
    endfunction

    function automatic int lookup_slot(logic [KEY_W-1:0] k);
        int idx;
        idx = home_slot(k);
        for (int n = 0; n < TABLE_SLOTS; n++)
        begin
            if (!tbl_used[idx])
                return -1;
            if (tbl_key[idx] == k)
                return idx;
            idx = (idx + 1) % TABLE_SLOTS;
        end
        return -1;
    endfunction

    function automatic void swap_due(int a, int b);
        bit [TIME_W-1:0] d;
        bit [11:0] s;
        d = due_time[a];
        s = due_slot[a];
        due_time[a] = due_time[b];
        due_slot[a] = due_slot[b];
        due_time[b] = d;
        due_slot[b] = s;
    endfunction

    function automatic void schedule_due(bit [TIME_W-1:0] d, int slot);
        int i;
        int p;
        i = due_count;
        due_count++;
        due_time[i] = d;
        due_slot[i] = 12'(slot);
        while (i != 0)
        begin
            p = (i - 1) / 2;
            if (due_time[p] <= due_time[i])
                break;
            swap_due(i, p);
            i = p;
        end
    endfunction

    function automatic void drop_earliest();
        int i;
        int l;
        int r;
        int m;
        i = 0;
        due_count--;
        due_time[0] = due_time[due_count];
        due_slot[0] = due_slot[due_count];
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            m = i;
            if (l < due_count && due_time[l] < due_time[m])
                m = l;
            if (r < due_count && due_time[r] < due_time[m])
                m = r;
            if (m == i)
                break;
            swap_due(i, m);
            i = m;
        end
    endfunction

    // queue one item and record the result the block must give for it
    function automatic void post_item(op_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] s,
                                      logic [LIMIT_W-1:0] lim);
        session_req_t req;
        session_rsp_t rsp;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] sec;
        int idx;
        bit found;
        bit [TIME_W-1:0] renew;
        bit [TIME_W-1:0] d;
        int hit;
        req.op = op;
        req.key = k;
        req.secret = s;
        req.idle_limit = lim;
        req_q.push_back(req);
        key = trim_key(k);
        sec = trim_key(s);
        rsp.expired = '0;
        rsp.status = ST_OK;
        case (op)
            OP_NEW:
            begin
                idx = home_slot(key);
                found = 1'b0;
                for (int n = 0; n < TABLE_SLOTS; n++)
                begin
                    if (!tbl_used[idx])
                    begin
                        found = 1'b1;
                        break;
                    end
                    idx = (idx + 1) % TABLE_SLOTS;
                end
                if (!found)
                    rsp.status = ST_TABLE_FULL;
                else if (due_count >= HEAP_SLOTS)
                    rsp.status = ST_HEAP_FULL;
                else
                begin
                    tbl_key[idx] = key;
                    tbl_secret[idx] = sec;
                    tbl_limit[idx] = lim;
                    tbl_expiry[idx] = now_tick + TIME_W'(lim);
                    tbl_used[idx] = 1'b1;
                    tbl_in[idx] = 1'b1;
                    schedule_due(tbl_expiry[idx], idx);
                end
            end
            OP_LOGOUT:
            begin
                idx = lookup_slot(key);
                if (idx < 0)
                    rsp.status = ST_NO_MATCH;
                else
                    tbl_in[idx] = 1'b0;
            end
            OP_CONNECT:
            begin
                idx = lookup_slot(key);
                if (idx < 0)
                    rsp.status = ST_NO_MATCH;
                else if (!tbl_in[idx] || tbl_expiry[idx] <= now_tick || tbl_secret[idx] != sec)
                    rsp.status = ST_NO_MATCH;
                else
                begin
                    renew = now_tick + TIME_W'(tbl_limit[idx]);
                    if (tbl_expiry[idx] != renew)
                    begin
                        if (due_count >= HEAP_SLOTS)
                            rsp.status = ST_HEAP_FULL;
                        else
                        begin
                            tbl_expiry[idx] = renew;
                            schedule_due(renew, idx);
                        end
                    end
                end
            end
            default:
            begin
                now_tick++;
                hit = 0;
                while (due_count > 0 && due_time[0] <= now_tick)
                begin
                    d = due_time[0];
                    idx = int'(due_slot[0]);
                    if (d == now_tick && tbl_in[idx] && tbl_expiry[idx] == now_tick && hit < 8191)
                        hit++;
                    drop_earliest();
                end
                rsp.expired = COUNT_W'(hit);
            end
        endcase
        rsp_q.push_back(rsp);
    endfunction

    function automatic logic [KEY_W-1:0] rand_string(int len, bit wide_codes);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < len; i++)
            k[CHAR_W*i +: CHAR_W] = CHAR_W'(wide_codes ? $urandom_range(1, 63)
                                                       : $urandom_range(1, 36));
        return k;
    endfunction

    // at random, fill the bits above the terminating zero code with noise
    function automatic logic [KEY_W-1:0] add_tail(logic [KEY_W-1:0] k);
        int n;
        logic [63:0] noise;
        n = 0;
        while (n < MAX_CHARS && k[CHAR_W*n +: CHAR_W] != 0)
            n++;
        noise = {$urandom, $urandom};
        if (n < MAX_CHARS - 1 && $urandom_range(0, 1))
            k = k | KEY_W'(noise << (CHAR_W * (n + 1)));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] rand_noise();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return rand_noise();
        return add_tail(rand_string($urandom_range(0, 5) == 0 ? $urandom_range(0, 10)
                                                                : $urandom_range(1, 4),
                                    $urandom_range(0, 4) == 0));
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return LIMIT_W'($urandom_range(0, 12));
        if (pick < 90)
            return LIMIT_W'($urandom_range(13, 400));
        return LIMIT_W'($urandom_range(0, 32767));
    endfunction

    task automatic build_stimulus();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] s;
        int pick;
        int a;

        // directed: extremes and the special cases
        post_item(OP_LOGOUT, rand_string(3, 1'b0), '0, '0);
        post_item(OP_CONNECT, rand_string(3, 1'b0), '0, '0);
        post_item(OP_NEW, '1, '1, '1);
        post_item(OP_CONNECT, '1, '1, '0);
        post_item(OP_NEW, '0, '0, '0);
        post_item(OP_NEW, 60'h0000_0000_0041_0C2, 60'h0000_0000_0000_083, 15'd1);
        post_item(OP_NEW, 60'h0000_0000_0041_0C2, 60'h0000_0000_0000_144, 15'd3);
        post_item(OP_CONNECT, 60'hABC_0000_0041_0C2, 60'hFFF0_0000_0000_083, '0);
        post_item(OP_CONNECT, 60'h0000_0000_0041_0C2, 60'h0000_0000_0000_144, '0);
        post_item(OP_NEW, 60'h0000_0000_0000_045, 60'h0000_0000_0000_045, 15'd30000);
        post_item(OP_NEW, 60'h0000_0000_0000_046, 60'h0000_0000_0000_046, 15'd2);
        post_item(OP_TICK, '0, '0, '0);
        post_item(OP_CONNECT, 60'h0000_0000_0000_046, 60'h0000_0000_0000_046, '0);
        post_item(OP_CONNECT, 60'h0000_0000_0000_046, 60'h0000_0000_0000_047, '0);
        post_item(OP_TICK, '0, '0, '0);
        post_item(OP_CONNECT, 60'h0000_0000_0041_0C2, 60'h0000_0000_0000_083, '0);
        post_item(OP_LOGOUT, 60'h0000_0000_0000_045, '0, '0);
        post_item(OP_CONNECT, 60'h0000_0000_0000_045, 60'h0000_0000_0000_045, '0);
        post_item(OP_TICK, '0, '0, '0);
        post_item(OP_TICK, '0, '0, '0);
        post_item(OP_CONNECT, 60'h0000_0000_0000_046, 60'h0000_0000_0000_046, '0);
        post_item(OP_LOGOUT, '1, rand_noise(), '1);
        post_item(OP_TICK, rand_noise(), rand_noise(), '1);

        // random mix of well-formed sessions with some noise
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            a = acct_key.size() > 0 ? $urandom_range(0, acct_key.size() - 1) : 0;
            if (pick < 28 || acct_key.size() == 0)
            begin
                k = ($urandom_range(0, 99) < 15 && acct_key.size() > 0) ? add_tail(acct_key[a])
                                                                        : rand_key();
                s = rand_key();
                acct_key.push_back(trim_key(k));
                acct_secret.push_back(trim_key(s));
                post_item(OP_NEW, k, s, rand_limit());
            end
            else if (pick < 43)
                post_item(OP_LOGOUT, $urandom_range(0, 3) != 0 ? add_tail(acct_key[a]) : rand_key(),
                          rand_noise(), LIMIT_W'($urandom));
            else if (pick < 75)
            begin
                k = $urandom_range(0, 9) != 0 ? add_tail(acct_key[a]) : rand_key();
                s = $urandom_range(0, 3) != 0 ? add_tail(acct_secret[a]) : rand_key();
                post_item(OP_CONNECT, k, s, LIMIT_W'($urandom));
            end
            else
                post_item(OP_TICK, rand_noise(), rand_noise(), LIMIT_W'($urandom));
        end

        // let short timers run out at the end
        for (int t = 0; t < 8; t++)
            post_item(OP_TICK, '0, '0, '0);
    endtask

    // sender: present items, idling now and then
    always @(negedge clk)
    begin
        session_req_t req;
        bit calm;
        calm = (taken >= 600 && taken < 1000);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_took)
        begin
            if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= 23))
            begin
                req = req_q.pop_front();
                s_tdata <= {1'b0, req.idle_limit, req.secret, req.key};
                s_tuser <= req.op;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && (calm || $urandom_range(0, 99) >= 23);
    end

    // receiver: check each result against the oldest expectation
    always @(posedge clk)
    begin
        session_rsp_t want;
        s_took <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            taken++;
        if (rst_n && m_tvalid && m_tready)
        begin
            returned++;
            if (rsp_q.size() == 0)
            begin
                $error("result with nothing expected: expired_count %0d status %0d",
                       m_tdata[COUNT_W-1:0], m_tuser);
                errors++;
            end
            else
            begin
                want = rsp_q.pop_front();
                status_seen[m_tuser]++;
                if (m_tdata[COUNT_W-1:0] > max_expired)
                    max_expired = m_tdata[COUNT_W-1:0];
                if (m_tdata[COUNT_W-1:0] !== want.expired)
                begin
                    $error("expired_count: expected %0d, got %0d", want.expired,
                           m_tdata[COUNT_W-1:0]);
                    errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** session_timeout_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (req_q.size() > 0 || s_tvalid || rsp_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (rsp_q.size() > 0)
        begin
            $error("%0d results never arrived", rsp_q.size());
            errors++;
        end
        $display("Ran %0d items, %0d results in %0d cycles, largest expiry count %0d.",
                 taken, returned, cycles, max_expired);
        $display("Status seen: ok %0d, table full %0d, heap full %0d, no match %0d.",
                 status_seen[ST_OK], status_seen[ST_TABLE_FULL], status_seen[ST_HEAP_FULL],
                 status_seen[ST_NO_MATCH]);
        if (errors == 0)
            $display("** session_timeout_table: PASSED **");
        else
            $display("** session_timeout_table: FAILED **");
        $finish;
    end

endmodule
